/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/mlqs_pkg.sv */
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared constants and control types of the multilevel queue slot scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlqs_pkg;

    localparam int DEF_LEVELS     = 8;
    localparam int DEF_FIFO_DEPTH = 16;
    localparam int DEF_ID_WIDTH   = 8;

    localparam int JOB_W     = 8;
    localparam int LVL_IN_W  = 3;
    localparam int TDATA_W   = 16;
    localparam int M_TUSER_W = 2;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam int TUSER_JOB_VALID = 0;
    localparam int TUSER_OVERFLOW  = 1;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_ctl;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/mlqs_ctrl.sv */
// ----------------------------------------------------------------------------
// mlqs_ctrl
// Request sequencer: accept, execute, then hand the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlqs_ctrl
    import mlqs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule

/* rtl/core/mlqs_dpath.sv */
// ----------------------------------------------------------------------------
// mlqs_dpath
// Level flags, priority scan, level record memory, job memory, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlqs_dpath
    import mlqs_pkg::*;
#(
    parameter int LEVELS     = DEF_LEVELS,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int ID_WIDTH   = DEF_ID_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output t_sts                 o_sts,
    input  logic [TDATA_W-1:0]   i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser
);

    localparam int LVL_W       = $clog2(LEVELS);
    localparam int SLOT_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int UW          = $clog2(LEVELS + 1);
    localparam int ADDR_W      = LVL_W + SLOT_W;
    localparam int STORE_DEPTH = LEVELS * (2 ** SLOT_W);
    localparam int PAD_W       = TDATA_W - JOB_W - LVL_IN_W;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic [CNT_W-1:0]  count;
        logic [UW-1:0]     used;
    } t_rec;

    t_rec                rec_mem   [LEVELS];
    logic [ID_WIDTH-1:0] job_store [STORE_DEPTH];

    logic [LEVELS-1:0]   r_lvl_vld;
    logic [LEVELS-1:0]   r_nonempty;
    logic [LEVELS-1:0]   r_has_credit;
    logic [LEVELS-1:0]   r_fresh;

    logic                r_cmd;
    logic [ID_WIDTH-1:0] r_id;
    logic [LVL_W-1:0]    r_idx;
    logic                r_put_ok;
    logic                r_any;
    logic                r_found;
    t_rec                r_rec;
    logic                r_rec_vld;
    logic [ID_WIDTH-1:0] r_sdata;
    logic                r_res_job;
    logic                r_res_ovf;
    logic [LVL_W-1:0]    r_res_lvl;
    logic                r_out_valid;
    logic [TDATA_W-1:0]  r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;

    logic [JOB_W-1:0]    in_job;
    logic [LVL_IN_W-1:0] in_lvl;
    logic [31:0]         in_lvl32;
    logic [31:0]         in_id32;
    logic                in_lvl_ok;
    logic                scan_any;
    logic                scan_found;
    logic [LVL_W-1:0]    first_sel;
    logic [LVL_W-1:0]    credit_sel;
    logic [LVL_W-1:0]    rd_idx;

    t_rec                rec;
    t_rec                rec_new;
    logic                is_get;
    logic                full;
    logic                do_put;
    logic                do_get;
    logic                refill;
    logic [UW-1:0]       used_base;
    logic [UW-1:0]       used_new;
    logic [UW-1:0]       credit_lim;
    logic [CNT_W-1:0]    cnt_dec;
    logic [LEVELS-1:0]   n_has_credit;
    logic [LEVELS-1:0]   n_fresh;
    logic [M_TUSER_W-1:0] n_out_user;
    logic [31:0]         sdata32;
    logic [31:0]         lvl32;
    logic [JOB_W-1:0]    out_job;
    logic [LVL_IN_W-1:0] out_lvl;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
        next_slot = (p == SLOT_W'(FIFO_DEPTH - 1)) ? '0 : SLOT_W'(p + 1'b1);
    endfunction

    // request decode and priority scan
    assign in_job    = i_s_tdata[JOB_W-1:0];
    assign in_lvl    = i_s_tdata[JOB_W +: LVL_IN_W];
    assign in_lvl32  = 32'(in_lvl);
    assign in_id32   = 32'(in_job);
    assign in_lvl_ok = (in_lvl32 < 32'(LEVELS));

    always_comb begin
        scan_any   = 1'b0;
        scan_found = 1'b0;
        first_sel  = '0;
        credit_sel = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                scan_any  = 1'b1;
                first_sel = LVL_W'(i);
            end
            if (r_nonempty[i] && r_has_credit[i]) begin
                scan_found = 1'b1;
                credit_sel = LVL_W'(i);
            end
        end
    end

    always_comb begin
        if (i_s_tuser == CMD_GET) begin
            rd_idx = scan_found ? credit_sel : first_sel;
        end else if (in_lvl_ok) begin
            rd_idx = in_lvl32[LVL_W-1:0];
        end else begin
            rd_idx = '0;
        end
    end

    // execute step
    assign rec        = r_rec_vld ? r_rec : '0;
    assign is_get     = (r_cmd == CMD_GET);
    assign full       = (rec.count == CNT_W'(FIFO_DEPTH));
    assign do_put     = !is_get && r_put_ok && !full;
    assign do_get     = is_get && r_any;
    assign refill     = do_get && !r_found;
    assign used_base  = (refill || r_fresh[r_idx]) ? '0 : rec.used;
    assign used_new   = UW'(used_base + 1'b1);
    assign credit_lim = UW'(LEVELS) - UW'(r_idx);
    assign cnt_dec    = CNT_W'(rec.count - 1'b1);

    always_comb begin
        rec_new = rec;
        if (do_put) begin
            rec_new.tail  = next_slot(rec.tail);
            rec_new.count = CNT_W'(rec.count + 1'b1);
        end else if (do_get) begin
            rec_new.head  = next_slot(rec.head);
            rec_new.count = cnt_dec;
            rec_new.used  = used_new;
        end
    end

    // refill all credits first, then spend one on the served level
    always_comb begin
        n_has_credit        = refill ? '1 : r_has_credit;
        n_fresh             = refill ? '1 : r_fresh;
        n_has_credit[r_idx] = (used_new != credit_lim);
        n_fresh[r_idx]      = 1'b0;
    end

    always_comb begin
        n_out_user                  = '0;
        n_out_user[TUSER_JOB_VALID] = r_res_job;
        n_out_user[TUSER_OVERFLOW]  = r_res_ovf;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_rec <= rec_mem[rd_idx];
        end
        if (i_ctl.exec && (do_put || do_get)) begin
            rec_mem[r_idx] <= rec_new;
        end
        if (i_ctl.exec && do_put) begin
            job_store[{r_idx, rec.tail}] <= r_id;
        end
        if (i_ctl.exec && do_get) begin
            r_sdata <= job_store[{r_idx, rec.head}];
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd     <= i_s_tuser;
            r_id      <= in_id32[ID_WIDTH-1:0];
            r_idx     <= rd_idx;
            r_put_ok  <= in_lvl_ok;
            r_any     <= scan_any;
            r_found   <= scan_found;
            r_rec_vld <= r_lvl_vld[rd_idx];
        end
        if (i_ctl.exec) begin
            r_res_job <= do_get;
            r_res_ovf <= !is_get && r_put_ok && full;
            r_res_lvl <= do_get ? r_idx : '0;
        end
        if (i_ctl.load) begin
            r_out_data <= {{PAD_W{1'b0}}, out_lvl, out_job};
            r_out_user <= n_out_user;
        end
    end

    // level flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld    <= '0;
            r_nonempty   <= '0;
            r_has_credit <= '1;
            r_fresh      <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.exec && do_put) begin
                r_lvl_vld[r_idx]  <= 1'b1;
                r_nonempty[r_idx] <= 1'b1;
            end
            if (i_ctl.exec && do_get) begin
                r_lvl_vld[r_idx]  <= 1'b1;
                r_nonempty[r_idx] <= (cnt_dec != '0);
                r_has_credit      <= n_has_credit;
                r_fresh           <= n_fresh;
            end
            if (i_ctl.load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign sdata32 = 32'(r_sdata);
    assign lvl32   = 32'(r_res_lvl);
    assign out_job = r_res_job ? sdata32[JOB_W-1:0] : '0;
    assign out_lvl = lvl32[LVL_IN_W-1:0];

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;
    assign o_m_tuser      = r_out_user;

endmodule

/* rtl/core/multilevel_queue_slot_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_queue_slot_scheduler
// Weighted round robin over per-level job FIFOs with slot credits.
// ----------------------------------------------------------------------------
// Each request is accepted while the record of its level is read (the level is
// picked by a priority scan on a get); then that record is updated and the job
// memory written or read; then the result moves into the output register, a
// step that waits while the output register is still held by the downstream
// side. A put appends to its level's FIFO, a get pops the first non-empty level
// with credit and refills all credits when none has any. No clearing pass
// follows reset.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module multilevel_queue_slot_scheduler
    import mlqs_pkg::*;
#(
    parameter int LEVELS     = DEF_LEVELS,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
    parameter int ID_WIDTH   = DEF_ID_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,  // job_id[7:0], level[10:8], zero pad
    input  logic                 s_axis_tuser,  // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,  // out_job_id[7:0], out_level[10:8], zero pad
    output logic [M_TUSER_W-1:0] m_axis_tuser   // job_valid[0], overflow[1]
);

    t_ctl w_ctl;
    t_sts w_sts;

    mlqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    mlqs_dpath #(
        .LEVELS     (LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    `ASSERT_NEXT(a_accept_then_exec, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, w_ctl.exec)
    `ASSERT_IMPLIES(a_load_when_free, i_clk, i_rst_n, w_ctl.load, !m_axis_tvalid || m_axis_tready)
    `ASSERT_IMPLIES(a_job_xor_ovf, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[TUSER_JOB_VALID] && m_axis_tuser[TUSER_OVERFLOW]))
    `ASSERT_NEXT(a_exec_no_accept, i_clk, i_rst_n, w_ctl.exec, !s_axis_tready)

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel queue slot scheduler. A scoreboard
// tracks the per-level job FIFOs and slot credits and predicts one dispatch
// record per request. A short directed run covers the empty get, the level
// extremes, a full level with a dropped put and a credit refill. A long random
// run follows, with phases that pile jobs into few levels, drain them, add idle
// gaps on the input side and apply random and sustained backpressure on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class sched_scoreboard;

    typedef struct {
        bit                        job_valid;
        bit [mlqs_pkg::JOB_W-1:0]    job_id;
        bit [mlqs_pkg::LVL_IN_W-1:0] lvl;
        bit                        overflow;
    } t_dispatch;

    bit [mlqs_pkg::JOB_W-1:0] job_mem [mlqs_pkg::DEF_LEVELS][mlqs_pkg::DEF_FIFO_DEPTH];
    bit [3:0]                 head_idx [mlqs_pkg::DEF_LEVELS];
    bit [3:0]                 tail_idx [mlqs_pkg::DEF_LEVELS];
    bit [4:0]                 fill_cnt [mlqs_pkg::DEF_LEVELS];
    bit [3:0]                 credit   [mlqs_pkg::DEF_LEVELS];

    t_dispatch pending_dispatches[$];

    int errors;
    int n_puts;
    int n_drops;
    int n_gets;
    int n_empty_gets;
    int n_refills;
    int n_checked;

    function new();
        for (int i = 0; i < mlqs_pkg::DEF_LEVELS; i++) begin
            head_idx[i] = '0;
            tail_idx[i] = '0;
            fill_cnt[i] = '0;
            credit[i]   = 4'(mlqs_pkg::DEF_LEVELS - i);
        end
    endfunction

    // predict the dispatch record of one accepted request
    function void schedule_request(bit cmd, bit [7:0] id, bit [2:0] lvl);
        t_dispatch r;
        bit        any;
        bit        found;
        int        sel;
        r     = '{default: '0};
        any   = 1'b0;
        found = 1'b0;
        sel   = 0;
        if (cmd == mlqs_pkg::CMD_PUT) begin
            n_puts++;
            if (int'(lvl) < mlqs_pkg::DEF_LEVELS) begin
                if (fill_cnt[lvl] >= mlqs_pkg::DEF_FIFO_DEPTH) begin
                    r.overflow = 1'b1;
                    n_drops++;
                end else begin
                    job_mem[lvl][tail_idx[lvl]] = id;
                    tail_idx[lvl] = tail_idx[lvl] + 1'b1;
                    fill_cnt[lvl] = fill_cnt[lvl] + 1'b1;
                end
            end
        end else begin
            n_gets++;
            for (int i = 0; i < mlqs_pkg::DEF_LEVELS; i++) begin
                if (fill_cnt[i] != 0) begin
                    if (!any) begin
                        any = 1'b1;
                        sel = i;
                    end
                    if (credit[i] != 0) begin
                        found = 1'b1;
                        sel   = i;
                        break;
                    end
                end
            end
            if (!any) begin
                n_empty_gets++;
            end else begin
                if (!found) begin
                    n_refills++;
                    for (int i = 0; i < mlqs_pkg::DEF_LEVELS; i++)
                        credit[i] = 4'(mlqs_pkg::DEF_LEVELS - i);
                end
                r.job_valid   = 1'b1;
                r.job_id      = job_mem[sel][head_idx[sel]];
                r.lvl         = 3'(sel);
                head_idx[sel] = head_idx[sel] + 1'b1;
                fill_cnt[sel] = fill_cnt[sel] - 1'b1;
                if (credit[sel] != 0)
                    credit[sel] = credit[sel] - 1'b1;
            end
        end
        pending_dispatches.push_back(r);
    endfunction

    function void check_dispatch(bit [mlqs_pkg::TDATA_W-1:0] tdata,
                                 bit [mlqs_pkg::M_TUSER_W-1:0] tuser);
        t_dispatch e;
        bit [7:0]  got_id;
        bit [2:0]  got_lvl;
        bit        got_valid;
        bit        got_ovf;
        got_id    = tdata[mlqs_pkg::JOB_W-1:0];
        got_lvl   = tdata[mlqs_pkg::JOB_W +: mlqs_pkg::LVL_IN_W];
        got_valid = tuser[mlqs_pkg::TUSER_JOB_VALID];
        got_ovf   = tuser[mlqs_pkg::TUSER_OVERFLOW];
        if (pending_dispatches.size() == 0) begin
            $error("unexpected result: tdata=%h tuser=%b", tdata, tuser);
            errors++;
            return;
        end
        e = pending_dispatches.pop_front();
        n_checked++;
        if (got_valid != e.job_valid) begin
            $error("job_valid: expected %0d, got %0d", e.job_valid, got_valid);
            errors++;
        end
        if (got_id != e.job_id) begin
            $error("out_job_id: expected %0d, got %0d", e.job_id, got_id);
            errors++;
        end
        if (got_lvl != e.lvl) begin
            $error("out_level: expected %0d, got %0d", e.lvl, got_lvl);
            errors++;
        end
        if (got_ovf != e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, got_ovf);
            errors++;
        end
    endfunction

endclass

module tb_top;

    import mlqs_pkg::*;

    localparam int RANDOM_REQUESTS = 1425;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;  // job_id[7:0], level[10:8], zero pad
    logic                 s_axis_tuser  = CMD_PUT;  // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;  // out_job_id[7:0], out_level[10:8], zero pad
    logic [M_TUSER_W-1:0] m_axis_tuser;  // job_valid[0], overflow[1]

    bit send_gaps = 1'b1;

    sched_scoreboard sb = new();

    multilevel_queue_slot_scheduler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.schedule_request(s_axis_tuser, s_axis_tdata[JOB_W-1:0],
                                    s_axis_tdata[JOB_W +: LVL_IN_W]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_dispatch(m_axis_tdata, m_axis_tuser);
        end
    end

    // downstream side: random stalls, one long hold, one stretch without stalls
    initial begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == 1500)
                hold = 300;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (cyc >= 4000 && cyc < 5500) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 31);
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [7:0] id, input logic [2:0] lvl);
        if (send_gaps && $urandom_range(0, 99) < 31) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W - JOB_W - LVL_IN_W){1'b0}}, lvl, id};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int put_pct [5];
        int phase;
        int waited;
        logic [2:0] lvl;
        put_pct = '{55, 85, 30, 65, 50};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty get, level extremes, full level with a drop, credit refill
        send_request(CMD_GET, 8'hFF, 3'd7);
        send_request(CMD_PUT, 8'hFF, 3'd0);
        send_request(CMD_PUT, 8'h5A, 3'd3);
        for (int i = 0; i < 17; i++)
            send_request(CMD_PUT, {4'(i), ~4'(i)}, 3'd7);
        repeat (5) send_request(CMD_GET, 8'h00, 3'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            phase     = n / 150;
            send_gaps = !(n >= 700 && n < 950);
            lvl       = (phase % 3 == 1) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 7));
            send_request(($urandom_range(0, 99) < put_pct[phase % 5]) ? CMD_PUT : CMD_GET,
                         8'($urandom_range(0, 255)), lvl);
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.pending_dispatches.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending_dispatches.size() != 0) begin
            $error("%0d results never arrived", sb.pending_dispatches.size());
            sb.errors += sb.pending_dispatches.size();
        end

        $display("Covered %0d puts (%0d dropped on a full level), %0d gets",
                 sb.n_puts, sb.n_drops, sb.n_gets);
        $display("(%0d on empty queues, %0d after a credit refill); checked %0d results",
                 sb.n_empty_gets, sb.n_refills, sb.n_checked);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mlqs_pkg.sv
rtl/core/mlqs_ctrl.sv
rtl/core/mlqs_dpath.sv
rtl/core/multilevel_queue_slot_scheduler.sv
sim/tb_top.sv
